/* rtl/drp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_pkg: shared definitions for the elevation data-record parser
// Widths, format constants, result codes and configuration register indexes.
// ----------------------------------------------------------------------------
package drp_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int CNT_W      = $clog2(MAX_POINTS);   // sample / record counters
    localparam int CFG_W      = 13;                   // configuration register width
    localparam int CFG_IDX_W  = 8;

    localparam logic [7:0]    SENTINEL_BYTE = 8'd170;
    localparam logic [2:0]    HEADER_BYTES  = 3'd7;
    localparam logic [2:0]    CHECKSUM_LAST = 3'd4;
    localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(1201);
    localparam logic [CFG_W-1:0] CFG_MAX    = CFG_W'(MAX_POINTS);

    localparam logic signed [15:0] ELEV_MAX_INIT = 16'sd32767;
    localparam logic signed [15:0] ELEV_MIN_INIT = -16'sd32767;

    // result codes
    localparam logic [1:0] KIND_SAMPLE       = 2'd0;
    localparam logic [1:0] KIND_CHECKSUM_OK  = 2'd1;
    localparam logic [1:0] KIND_BAD_SENTINEL = 2'd2;
    localparam logic [1:0] KIND_MISMATCH     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_RECORD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_COUNT       = CFG_IDX_W'(1);

    // saturate a register value at MAX_POINTS
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v);
        return (v > CFG_MAX) ? CFG_MAX : v;
    endfunction

endpackage

/* rtl/dted_record_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dted_record_parser: terrain elevation data-record parser
// Parses sentinel, header, sign-magnitude samples and checksum byte by byte.
// ----------------------------------------------------------------------------
// A result appears on out_valid in the cycle after the byte transfer that
// causes it. Throughput: one byte per cycle; in_ready drops only while
// a finished result is held and out_ready is low.
// Reset (rst_n, async, active low): parser waits for a sentinel, counters and
// sums clear, min/max return to +/-32767, both registers return to 1201.
// Config writes are always accepted (cfg_ready tied high) and act at once.
module dted_record_parser
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic signed [15:0]           elevation,
    output logic [drp_pkg::CNT_W-1:0]    column_index,
    output logic [drp_pkg::CNT_W-1:0]    row_index,
    output logic signed [15:0]           min_elevation,
    output logic signed [15:0]           max_elevation,
    output logic                         last_record,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [drp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drp_pkg::CFG_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        PH_SENTINEL,
        PH_HEADER,
        PH_SAMPLES,
        PH_CHECKSUM
    } phase_t;

    localparam int CNT_W = drp_pkg::CNT_W;
    localparam int CFG_W = drp_pkg::CFG_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   spr_cfg_reg, spr_cfg_next;
    logic [CFG_W-1:0]   rc_cfg_reg, rc_cfg_next;

    phase_t             phase_reg, phase_next;
    logic [2:0]         byte_cnt_reg, byte_cnt_next;
    logic [CNT_W-1:0]   sample_cnt_reg, sample_cnt_next;
    logic [CNT_W-1:0]   record_cnt_reg, record_cnt_next;
    logic [31:0]        sum_reg, sum_next;
    logic [7:0]         high_byte_reg, high_byte_next;
    logic [31:0]        checksum_reg, checksum_next;
    logic signed [15:0] min_reg, min_next;
    logic signed [15:0] max_reg, max_next;
    logic               halted_reg, halted_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic signed [15:0] elev_reg, elev_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic signed [15:0] min_out_reg, min_out_next;
    logic signed [15:0] max_out_reg, max_out_next;
    logic               last_reg, last_next;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic               in_xfer;
    logic [CFG_W-1:0]   spr;
    logic [CFG_W-1:0]   rc;
    logic [15:0]        raw;
    logic [15:0]        mag_ext;
    logic signed [15:0] elev;
    logic [31:0]        checksum_shift;
    logic [2:0]         byte_cnt_inc;
    logic               final_record;
    logic               emit;

    assign cfg_ready = 1'b1;
    // hold off input only while a result sits unclaimed
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    assign spr = drp_pkg::clamp_cfg(spr_cfg_reg);
    assign rc  = drp_pkg::clamp_cfg(rc_cfg_reg);

    // sign-magnitude decode; negative zero folds to zero
    assign raw     = {high_byte_reg, data_byte};
    assign mag_ext = {1'b0, raw[14:0]};
    assign elev    = raw[15] ? $signed(16'(-mag_ext)) : $signed(mag_ext);

    assign checksum_shift = {checksum_reg[23:0], data_byte};
    assign byte_cnt_inc   = byte_cnt_reg + 3'd1;
    assign final_record   = ({1'b0, record_cnt_reg} + CFG_W'(1)) >= rc;

    always_comb
    begin
        spr_cfg_next    = spr_cfg_reg;
        rc_cfg_next     = rc_cfg_reg;
        phase_next      = phase_reg;
        byte_cnt_next   = byte_cnt_reg;
        sample_cnt_next = sample_cnt_reg;
        record_cnt_next = record_cnt_reg;
        sum_next        = sum_reg;
        high_byte_next  = high_byte_reg;
        checksum_next   = checksum_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        halted_next     = halted_reg;

        emit            = 1'b0;
        kind_next       = kind_reg;
        elev_next       = elev_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        min_out_next    = min_out_reg;
        max_out_next    = max_out_reg;
        last_next       = last_reg;

        if (cfg_valid)
        begin
            if (cfg_index == drp_pkg::REG_SAMPLES_PER_RECORD)
                spr_cfg_next = cfg_data;
            else if (cfg_index == drp_pkg::REG_RECORD_COUNT)
                rc_cfg_next = cfg_data;
        end

        if (in_xfer && !halted_reg)
        begin
            case (phase_reg)
                PH_SENTINEL:
                begin
                    // stream done: extra bytes fall through silently
                    if ({1'b0, record_cnt_reg} < rc)
                    begin
                        if (data_byte != drp_pkg::SENTINEL_BYTE)
                        begin
                            halted_next  = 1'b1;
                            emit         = 1'b1;
                            kind_next    = drp_pkg::KIND_BAD_SENTINEL;
                            elev_next    = '0;
                            col_next     = '0;
                            row_next     = record_cnt_reg;
                            min_out_next = min_reg;
                            max_out_next = max_reg;
                            last_next    = 1'b0;
                        end
                        else
                        begin
                            sum_next        = 32'(drp_pkg::SENTINEL_BYTE);
                            byte_cnt_next   = '0;
                            sample_cnt_next = '0;
                            checksum_next   = '0;
                            phase_next      = PH_HEADER;
                        end
                    end
                end

                PH_HEADER:
                begin
                    sum_next      = sum_reg + 32'(data_byte);
                    byte_cnt_next = byte_cnt_inc;
                    if (byte_cnt_inc >= drp_pkg::HEADER_BYTES)
                    begin
                        byte_cnt_next = '0;
                        phase_next    = (spr == '0) ? PH_CHECKSUM : PH_SAMPLES;
                    end
                end

                PH_SAMPLES:
                begin
                    sum_next = sum_reg + 32'(data_byte);
                    if (!byte_cnt_reg[0])
                    begin
                        high_byte_next = data_byte;
                        byte_cnt_next  = 3'd1;
                    end
                    else
                    begin
                        byte_cnt_next = '0;
                        if (elev < min_reg)
                            min_next = elev;
                        if (elev > max_reg)
                            max_next = elev;
                        if (({1'b0, sample_cnt_reg} + CFG_W'(1)) >= spr)
                            phase_next = PH_CHECKSUM;
                        else
                            sample_cnt_next = sample_cnt_reg + CNT_W'(1);

                        emit         = 1'b1;
                        kind_next    = drp_pkg::KIND_SAMPLE;
                        elev_next    = elev;
                        col_next     = sample_cnt_reg;
                        row_next     = record_cnt_reg;
                        min_out_next = (elev < min_reg) ? elev : min_reg;
                        max_out_next = (elev > max_reg) ? elev : max_reg;
                        last_next    = 1'b0;
                    end
                end

                PH_CHECKSUM:
                begin
                    checksum_next = checksum_shift;
                    byte_cnt_next = byte_cnt_inc;
                    if (byte_cnt_inc >= drp_pkg::CHECKSUM_LAST)
                    begin
                        byte_cnt_next = '0;
                        phase_next    = PH_SENTINEL;
                        emit          = 1'b1;
                        kind_next     = (checksum_shift == sum_reg) ?
                                        drp_pkg::KIND_CHECKSUM_OK :
                                        drp_pkg::KIND_MISMATCH;
                        elev_next     = '0;
                        col_next      = '0;
                        row_next      = record_cnt_reg;
                        min_out_next  = min_reg;
                        max_out_next  = max_reg;
                        last_next     = final_record;
                        if ((checksum_shift != sum_reg) || final_record)
                            halted_next = 1'b1;
                        else
                            record_cnt_next = record_cnt_reg + CNT_W'(1);
                    end
                end

                default:
                begin
                    phase_next = PH_SENTINEL;
                end
            endcase
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ------------------------------------------------------------------
    // State and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_cfg_reg    <= drp_pkg::CFG_RESET;
            rc_cfg_reg     <= drp_pkg::CFG_RESET;
            phase_reg      <= PH_SENTINEL;
            byte_cnt_reg   <= '0;
            sample_cnt_reg <= '0;
            record_cnt_reg <= '0;
            sum_reg        <= '0;
            high_byte_reg  <= '0;
            checksum_reg   <= '0;
            min_reg        <= drp_pkg::ELEV_MAX_INIT;
            max_reg        <= drp_pkg::ELEV_MIN_INIT;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= '0;
            elev_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            min_out_reg    <= '0;
            max_out_reg    <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            spr_cfg_reg    <= spr_cfg_next;
            rc_cfg_reg     <= rc_cfg_next;
            phase_reg      <= phase_next;
            byte_cnt_reg   <= byte_cnt_next;
            sample_cnt_reg <= sample_cnt_next;
            record_cnt_reg <= record_cnt_next;
            sum_reg        <= sum_next;
            high_byte_reg  <= high_byte_next;
            checksum_reg   <= checksum_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            halted_reg     <= halted_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            elev_reg       <= elev_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            min_out_reg    <= min_out_next;
            max_out_reg    <= max_out_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign elevation     = elev_reg;
    assign column_index  = col_reg;
    assign row_index     = row_reg;
    assign min_elevation = min_out_reg;
    assign max_elevation = max_out_reg;
    assign last_record   = last_reg;

endmodule
